@@ design/fics_pkg.sv @@
`default_nettype none

package fics_pkg;

	// Field widths fixed by the interface
	localparam int CODE_W    = 16;
	localparam int BAND_W    = 15;
	localparam int SETTLE_W  = 10;
	localparam int COUNT_W   = 16;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 3;

	// Smoother: Q16.8 state, alpha = 57672 / 65536
	localparam int SMOOTH_W = 24;
	localparam int SM_ACC_W = 42;
	localparam logic signed [SM_ACC_W-1:0] ALPHA_Q16     = 42'sd57672;
	localparam logic signed [SM_ACC_W-1:0] BETA_Q16_X256 = 42'sd2013184; // 7864 * 256
	localparam logic signed [SM_ACC_W-1:0] SM_ROUND      = 42'sd32768;

	// Band compare width: smoothed minus target*256 plus sign
	localparam int DIFF_W = 26;

	// Controller: third order, coefficients with 16 fraction bits
	localparam int IIR_ORDER = 3;
	localparam int COEF_W    = 19;
	localparam int LO_W      = 40;
	localparam int LO_RND_W  = 24;
	localparam logic signed [COEF_W-1:0] COEF_A [IIR_ORDER] = '{
		19'sd188023, -19'sd179503, 19'sd57029
	};
	localparam logic signed [COEF_W-1:0] COEF_B [IIR_ORDER] = '{
		-19'sd5093, 19'sd9562, -19'sd4469
	};
	localparam logic signed [LO_W-1:0] LO_ROUND = 40'sd32768;

	// Register reset values
	localparam logic signed [CODE_W-1:0]  OP_DRIVE_RST     = 16'sd26214;
	localparam logic signed [CODE_W-1:0]  OP_TARGET_RST    = 16'sd7537;
	localparam logic        [BAND_W-1:0]  OP_BAND_RST      = 15'd164;
	localparam logic        [SETTLE_W-1:0] SETTLE_COUNT_RST = 10'd50;
	localparam logic        [COUNT_W-1:0] WAIT_LIMIT_RST   = 16'd3000;
	localparam logic        [COUNT_W-1:0] RUN_LENGTH_RST   = 16'd9000;
	localparam logic        [SETTLE_W-1:0] SETTLE_MAX      = 10'h3FF;

	// Configuration register index
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OP_DRIVE     = 3'd0,
		CFG_OP_TARGET    = 3'd1,
		CFG_OP_BAND      = 3'd2,
		CFG_SETTLE_COUNT = 3'd3,
		CFG_WAIT_LIMIT   = 3'd4,
		CFG_RUN_LENGTH   = 3'd5
	} cfg_index_t;

	// Sticky run status
	typedef enum logic [STATUS_W-1:0] {
		ST_RUNNING  = 2'd0,
		ST_TIMEOUT  = 2'd1,
		ST_COMPLETE = 2'd2
	} status_t;

	// Operating mode, one-hot
	typedef enum logic [1:0] {
		MODE_WAIT = 2'b01,
		MODE_CTRL = 2'b10
	} mode_t;

	typedef struct packed {
		logic signed [CODE_W-1:0] sample;
		logic signed [CODE_W-1:0] setpoint;
	} in_item_t;

	typedef struct packed {
		logic signed [CODE_W-1:0]  drive;
		logic signed [CODE_W-1:0]  filtered;
		logic                      mode;
		logic        [STATUS_W-1:0] status;
		logic        [COUNT_W-1:0] run_index;
	} out_item_t;

endpackage

`default_nettype wire

@@ design/filtered_iir_control_with_settle_wait.sv @@
`default_nettype none
// An accepted request waits in the input register until its result can enter the
// result register (out_item). Throughput: one request per cycle while the result is not stalled;
// the loop through the smoother and controller history is combinational between the two registers.
// Reset (arst_n low, asynchronous): wait mode, status running, counters, median
// window, smoother and histories cleared, registers to their default operating point.
module filtered_iir_control_with_settle_wait
	import fics_pkg::*;
#(
	parameter int MEDIAN_TAPS   = 5,
	parameter int HISTORY_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CODE_W-1:0]    cfg_data
);

	localparam int HW    = HISTORY_WIDTH;
	localparam int WIDE  = HW + 10;
	localparam int DX_W  = HW + 1;
	localparam int MED_K = MEDIAN_TAPS / 2;
	localparam int CNT_W = $clog2(MEDIAN_TAPS + 1);

	localparam logic signed [WIDE-1:0] HMAX_W = WIDE'((64'sd1 <<< (HW - 1)) - 64'sd1);
	localparam logic signed [WIDE-1:0] HMIN_W = ~HMAX_W;
	localparam logic signed [DX_W-1:0] DRV_RND = DX_W'(32768);
	localparam logic signed [DX_W-1:0] DRV_MAX = DX_W'(32767);
	localparam logic signed [DX_W-1:0] DRV_MIN = -DX_W'(32768);

	// Saturate a wide value to the history width
	function automatic logic signed [HW-1:0] sat_hist(input logic signed [WIDE-1:0] v);
		logic signed [HW-1:0] r;
		if (v > HMAX_W) begin
			r = HMAX_W[HW-1:0];
		end else if (v < HMIN_W) begin
			r = HMIN_W[HW-1:0];
		end else begin
			r = v[HW-1:0];
		end
		return r;
	endfunction

	// Configuration registers
	logic signed [CODE_W-1:0]   op_drive_q, op_target_q;
	logic        [BAND_W-1:0]   op_band_q;
	logic        [SETTLE_W-1:0] settle_count_q;
	logic        [COUNT_W-1:0]  wait_limit_q, run_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_drive_q     <= OP_DRIVE_RST;
			op_target_q    <= OP_TARGET_RST;
			op_band_q      <= OP_BAND_RST;
			settle_count_q <= SETTLE_COUNT_RST;
			wait_limit_q   <= WAIT_LIMIT_RST;
			run_length_q   <= RUN_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_OP_DRIVE:     op_drive_q     <= cfg_data;
				CFG_OP_TARGET:    op_target_q    <= cfg_data;
				CFG_OP_BAND:      op_band_q      <= cfg_data[BAND_W-1:0];
				CFG_SETTLE_COUNT: settle_count_q <= cfg_data[SETTLE_W-1:0];
				CFG_WAIT_LIMIT:   wait_limit_q   <= cfg_data;
				CFG_RUN_LENGTH:   run_length_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: input register, result register
	logic      s1_valid_q;
	in_item_t  s1_item_q;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      adv;

	assign adv       = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall  = s1_valid_q && !adv;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_item_q <= in_item;
		end
	end

	// Block state
	logic signed [CODE_W-1:0]   win_q [MEDIAN_TAPS];
	logic signed [SMOOTH_W-1:0] smoothed_q;
	mode_t                      mode_q;
	status_t                    status_q;
	logic        [SETTLE_W-1:0] settle_cnt_q;
	logic        [COUNT_W-1:0]  wait_cnt_q, run_cnt_q;
	logic signed [HW-1:0]       dh_q [IIR_ORDER];
	logic signed [HW-1:0]       eh_q [IIR_ORDER];

	// Next-state and result logic
	logic signed [CODE_W-1:0]   win_d [MEDIAN_TAPS];
	logic        [CNT_W-1:0]    lt_cnt [MEDIAN_TAPS];
	logic        [CNT_W-1:0]    le_cnt [MEDIAN_TAPS];
	logic signed [CODE_W-1:0]   med;
	logic signed [SM_ACC_W-1:0] sm_acc;
	logic signed [SMOOTH_W-1:0] sm_d;
	logic signed [SMOOTH_W:0]   filt_x;
	logic signed [SMOOTH_W-8:0] filt_sh;
	logic signed [CODE_W-1:0]   filt;
	logic signed [DIFF_W-1:0]   diff;
	logic        [DIFF_W-1:0]   diff_mag;
	logic                       in_band;
	logic        [SETTLE_W-1:0] settle_d;
	logic        [COUNT_W:0]    wait_inc, run_inc;
	logic signed [HW-17:0]      hi_d [IIR_ORDER];
	logic signed [HW-17:0]      hi_e [IIR_ORDER];
	logic signed [WIDE-1:0]     hi_sum;
	logic signed [LO_W-1:0]     lo_sum;
	logic signed [LO_RND_W-1:0] lo_rnd;
	logic signed [HW-1:0]       u;
	logic signed [HW-1:0]       err;
	logic signed [HW-1:0]       seed;
	logic signed [DX_W-1:0]     drv_x;
	logic signed [CODE_W-1:0]   drv_sat;
	logic                       halted;
	logic                       go_timeout, go_ctrl, go_done;
	out_item_t                  res;

	assign halted = (status_q != ST_RUNNING);

	// Median of the shifted window by rank counting
	always_comb begin
		win_d[0] = s1_item_q.sample;
		for (int i = 1; i < MEDIAN_TAPS; i++) begin
			win_d[i] = win_q[i-1];
		end
		med = win_d[0];
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			lt_cnt[i] = '0;
			le_cnt[i] = '0;
			for (int j = 0; j < MEDIAN_TAPS; j++) begin
				lt_cnt[i] = lt_cnt[i] + CNT_W'(win_d[j] <  win_d[i]);
				le_cnt[i] = le_cnt[i] + CNT_W'(win_d[j] <= win_d[i]);
			end
		end
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			if (lt_cnt[i] <= CNT_W'(MED_K) && le_cnt[i] > CNT_W'(MED_K)) begin
				med = win_d[i];
			end
		end
	end

	// Exponential smoother and rounded code; frozen value shown when halted
	always_comb begin
		sm_acc = SM_ACC_W'(smoothed_q) * ALPHA_Q16 + SM_ACC_W'(med) * BETA_Q16_X256
			+ SM_ROUND;
		sm_d = SMOOTH_W'(sm_acc >>> 16);
		filt_x = halted ? (SMOOTH_W+1)'(smoothed_q) : (SMOOTH_W+1)'(sm_d);
		filt_x = filt_x + (SMOOTH_W+1)'(128);
		filt_sh = (SMOOTH_W-7)'(filt_x >>> 8);
		if (filt_sh > (SMOOTH_W-7)'(32767)) begin
			filt = 16'sh7FFF;
		end else if (filt_sh < -(SMOOTH_W-7)'(32768)) begin
			filt = 16'sh8000;
		end else begin
			filt = filt_sh[CODE_W-1:0];
		end
	end

	// Wait mode: band test and counters
	always_comb begin
		diff = DIFF_W'(sm_d) - (DIFF_W'(op_target_q) <<< 8);
		diff_mag = (diff < 0) ? DIFF_W'(-diff) : DIFF_W'(diff);
		in_band = diff_mag < DIFF_W'({op_band_q, 8'h00});
		if (!in_band) begin
			settle_d = '0;
		end else if (settle_cnt_q != SETTLE_MAX) begin
			settle_d = settle_cnt_q + 1'b1;
		end else begin
			settle_d = settle_cnt_q;
		end
		wait_inc = {1'b0, wait_cnt_q} + 1'b1;
		run_inc  = {1'b0, run_cnt_q} + 1'b1;
		go_timeout = wait_inc >= {1'b0, wait_limit_q};
		go_ctrl    = !go_timeout && (settle_d >= settle_count_q);
		go_done    = run_inc >= {1'b0, run_length_q};
		seed = sat_hist(WIDE'(op_drive_q) <<< 16);
	end

	// Third-order controller: hi/lo split products, one rounding of the low parts
	always_comb begin
		hi_sum = '0;
		lo_sum = '0;
		for (int i = 0; i < IIR_ORDER; i++) begin
			hi_d[i] = (HW-16)'(dh_q[i] >>> 16);
			hi_e[i] = (HW-16)'(eh_q[i] >>> 16);
			hi_sum = hi_sum + WIDE'(hi_d[i]) * WIDE'(COEF_A[i])
				+ WIDE'(hi_e[i]) * WIDE'(COEF_B[i]);
			lo_sum = lo_sum + LO_W'(signed'({1'b0, dh_q[i][15:0]})) * LO_W'(COEF_A[i])
				+ LO_W'(signed'({1'b0, eh_q[i][15:0]})) * LO_W'(COEF_B[i]);
		end
		lo_rnd = LO_RND_W'((lo_sum + LO_ROUND) >>> 16);
		u = sat_hist(hi_sum + WIDE'(lo_rnd));
		err = sat_hist((WIDE'(s1_item_q.setpoint) <<< 16) - (WIDE'(sm_d) <<< 8));
		drv_x = (DX_W'(u) + DRV_RND) >>> 16;
		if (drv_x > DRV_MAX) begin
			drv_sat = 16'sh7FFF;
		end else if (drv_x < DRV_MIN) begin
			drv_sat = 16'sh8000;
		end else begin
			drv_sat = drv_x[CODE_W-1:0];
		end
	end

	// Result assembly
	always_comb begin
		res.filtered  = filt;
		res.mode      = (mode_q == MODE_CTRL);
		res.drive     = '0;
		res.run_index = '0;
		res.status    = status_q;
		if (!halted) begin
			if (mode_q == MODE_WAIT) begin
				res.drive = op_drive_q;
				if (go_timeout) begin
					res.status = ST_TIMEOUT;
				end
			end else begin
				res.drive     = drv_sat;
				res.run_index = run_cnt_q;
				if (go_done) begin
					res.status = ST_COMPLETE;
				end
			end
		end
	end

	// State update, frozen once halted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MEDIAN_TAPS; i++) begin
				win_q[i] <= '0;
			end
			for (int i = 0; i < IIR_ORDER; i++) begin
				dh_q[i] <= '0;
				eh_q[i] <= '0;
			end
			smoothed_q   <= '0;
			mode_q       <= MODE_WAIT;
			status_q     <= ST_RUNNING;
			settle_cnt_q <= '0;
			wait_cnt_q   <= '0;
			run_cnt_q    <= '0;
		end else if (adv && !halted) begin
			for (int i = 0; i < MEDIAN_TAPS; i++) begin
				win_q[i] <= win_d[i];
			end
			smoothed_q <= sm_d;
			status_q   <= status_t'(res.status);
			if (mode_q == MODE_WAIT) begin
				settle_cnt_q <= settle_d;
				wait_cnt_q   <= wait_inc[COUNT_W-1:0];
				if (go_ctrl) begin
					mode_q <= MODE_CTRL;
					for (int i = 0; i < IIR_ORDER; i++) begin
						dh_q[i] <= seed;
						eh_q[i] <= '0;
					end
				end
			end else begin
				run_cnt_q <= run_inc[COUNT_W-1:0];
				dh_q[0]   <= u;
				eh_q[0]   <= err;
				for (int i = 1; i < IIR_ORDER; i++) begin
					dh_q[i] <= dh_q[i-1];
					eh_q[i] <= eh_q[i-1];
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= res;
		end
	end

	// Checks
	a_status_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != ST_RUNNING |=> status_q == $past(status_q))
		else $error("halt status changed after being set");

	a_ctrl_stays: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_CTRL |=> mode_q == MODE_CTRL)
		else $error("left control mode");

	a_run_idle_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_WAIT |-> run_cnt_q == '0)
		else $error("run counter moved in wait mode");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_wait_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !halted && mode_q == MODE_WAIT)
		|=> wait_cnt_q == $past(wait_cnt_q) + 1'b1)
		else $error("wait counter did not advance");

endmodule

`default_nettype wire
